// File: hdl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants
// Command, result and register codes, queue sizing and config structs for the
// PDO transmit trigger.
// ----------------------------------------------------------------------------
package tpt_pkg;

	localparam int Q_DEPTH = 16;
	localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QF_W    = $clog2(Q_DEPTH + 1);
	localparam int QS_W    = QA_W + 1;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int TIME_W  = 48;

	localparam logic [7:0] TT_ACYCLIC  = 8'h00;
	localparam logic [7:0] TT_CYC_MAX  = 8'hF0;
	localparam logic [7:0] TT_RTR_SYNC = 8'hFC;
	localparam logic [7:0] TT_RTR_ONLY = 8'hFD;
	localparam logic [7:0] TT_EVT_MIN  = 8'hFE;
	localparam logic [7:0] SYNC_CNT_MAX = 8'd240;

	typedef enum logic [1:0] {
		CMD_EVENT  = 2'd0,
		CMD_SYNC   = 2'd1,
		CMD_RTR    = 2'd2,
		CMD_EXPIRE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_BUFFER  = 3'd2,
		ACT_INHIBIT = 3'd3,
		ACT_BAD_CNT = 3'd4,
		ACT_FAULT   = 3'd5,
		ACT_WIN_TO  = 3'd6,
		ACT_FULL    = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		REG_COB_ID     = 3'd0,
		REG_TRANS_TYPE = 3'd1,
		REG_INHIBIT    = 3'd2,
		REG_EVT_PERIOD = 3'd3,
		REG_SYNC_START = 3'd4,
		REG_WIN_LEN    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] cob_id;
		logic [7:0]  trans_type;
		logic [15:0] inhibit_time;
		logic [15:0] event_period;
		logic [7:0]  sync_start;
		logic [31:0] window_length;
	} cfg_t;

	// side effects of a cob_id / trans_type write on the trigger state
	typedef struct packed {
		logic revalidate;
		logic clr_pending;
		logic clr_queue;
	} cfg_evt_t;

endpackage

// File: hdl/tpt_in_if.sv
// ----------------------------------------------------------------------------
// tpt_in_if: trigger request channel
// Valid/ready channel carrying one command with its sampled payload.
// ----------------------------------------------------------------------------
interface tpt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  sync_count;
	logic [47:0] now_time;
	logic [63:0] frame_data;
	logic [3:0]  frame_len;
	logic        map_fault;

	modport source (
		output valid, cmd, sync_count, now_time, frame_data, frame_len, map_fault,
		input  ready
	);
	modport sink (
		input  valid, cmd, sync_count, now_time, frame_data, frame_len, map_fault,
		output ready
	);
endinterface

// File: hdl/tpt_out_if.sv
// ----------------------------------------------------------------------------
// tpt_out_if: trigger result channel
// Valid/ready channel carrying the decision and the frame to send.
// ----------------------------------------------------------------------------
interface tpt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [28:0] can_id;
	logic        extended_id;
	logic [63:0] payload;
	logic [3:0]  payload_len;
	logic        rearm_event_timer;
	logic        rearm_window_timer;

	modport source (
		output valid, action, can_id, extended_id, payload, payload_len,
		       rearm_event_timer, rearm_window_timer,
		input  ready
	);
	modport sink (
		input  valid, action, can_id, extended_id, payload, payload_len,
		       rearm_event_timer, rearm_window_timer,
		output ready
	);
endinterface

// File: hdl/tpt_regs.sv
// ----------------------------------------------------------------------------
// tpt_regs: configuration registers
// APB register file; flags the state side effects of cob_id and trans_type
// writes.
// ----------------------------------------------------------------------------
module tpt_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tpt_pkg::PADDR_W-1:0] paddr,
	input  logic [tpt_pkg::PDATA_W-1:0] pwdata,
	output logic [tpt_pkg::PDATA_W-1:0] prdata,
	output logic                      pready,
	output tpt_pkg::cfg_t             cfg,
	output tpt_pkg::cfg_evt_t         cfg_evt
);
	import tpt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;
	logic     wr_cob;
	logic     wr_tt;
	logic     new_valid;
	logic [7:0] new_tt;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign wr_cob = wr && (idx == REG_COB_ID);
	assign wr_tt  = wr && (idx == REG_TRANS_TYPE);

	assign new_valid = wr_cob ? ~pwdata[31] : ~cfg_q.cob_id[31];
	assign new_tt    = wr_tt ? pwdata[7:0] : cfg_q.trans_type;

	assign cfg_evt.revalidate  = wr_cob & cfg_q.cob_id[31] & ~pwdata[31];
	assign cfg_evt.clr_pending = wr_tt | (wr_cob & cfg_q.cob_id[31] & ~pwdata[31]);
	assign cfg_evt.clr_queue   = (wr_cob | wr_tt) & ~(new_valid && new_tt == TT_RTR_SYNC);

	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cob_id        <= 32'h8000_0000;
			cfg_q.trans_type    <= 8'hFF;
			cfg_q.inhibit_time  <= '0;
			cfg_q.event_period  <= '0;
			cfg_q.sync_start    <= '0;
			cfg_q.window_length <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_COB_ID:     cfg_q.cob_id        <= pwdata;
				REG_TRANS_TYPE: cfg_q.trans_type    <= pwdata[7:0];
				REG_INHIBIT:    cfg_q.inhibit_time  <= pwdata[15:0];
				REG_EVT_PERIOD: cfg_q.event_period  <= pwdata[15:0];
				REG_SYNC_START: cfg_q.sync_start    <= pwdata[7:0];
				REG_WIN_LEN:    cfg_q.window_length <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COB_ID:     prdata = cfg_q.cob_id;
			REG_TRANS_TYPE: prdata = {24'd0, cfg_q.trans_type};
			REG_INHIBIT:    prdata = {16'd0, cfg_q.inhibit_time};
			REG_EVT_PERIOD: prdata = {16'd0, cfg_q.event_period};
			REG_SYNC_START: prdata = {24'd0, cfg_q.sync_start};
			REG_WIN_LEN:    prdata = cfg_q.window_length;
			default:        prdata = '0;
		endcase
	end

endmodule

// File: hdl/pdo_transmit_trigger.sv
// ----------------------------------------------------------------------------
// pdo_transmit_trigger: CANopen TPDO transmission trigger
// Decides per command whether a PDO is sent, buffered, inhibited or refused,
// and holds RTR-synchronous frames in a FIFO memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        carries
//  item      in   valid/ready      cmd, sync_count, now_time, frame_data, ...
//  result    out  valid/ready      action, can_id, payload, rearm flags
//  apb       in   psel/penable     six 32-bit config registers at 4*i
//
//  One item per cycle sustained while results are taken; an accepted item
//  is registered into s1, which decides and updates state, and its result
//  is registered into s2, which holds the result and the FIFO read data
//  from a registered RAM read.
//  No clearing pass after reset: FIFO entries are only read once written.
//  A stalled result holds s2; s1 then holds too and item.ready drops.
// ----------------------------------------------------------------------------
module pdo_transmit_trigger (
	input  logic                        clk,
	input  logic                        arst_n,
	tpt_in_if.sink                      item,
	tpt_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpt_pkg::PADDR_W-1:0] paddr,
	input  logic [tpt_pkg::PDATA_W-1:0] pwdata,
	output logic [tpt_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import tpt_pkg::*;

	cfg_t     cfg;
	cfg_evt_t cfg_evt;

	tpt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_evt (cfg_evt)
	);

	// trigger state
	logic              ep_q;
	logic              we_q;
	logic [7:0]        sw_q;
	logic [7:0]        sc_q;
	logic [TIME_W-1:0] na_q;
	logic [QA_W-1:0]   head_q;
	logic [QF_W-1:0]   fill_q;

	logic [67:0] mem [Q_DEPTH];
	logic [67:0] rd_q;

	// stage 1
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [7:0]        cnt_s1;
	logic [TIME_W-1:0] now_s1;
	logic [63:0]       data_s1;
	logic [3:0]        len_s1;
	logic              fault_s1;

	// stage 2
	logic        valid_s2;
	act_t        act_s2;
	logic [28:0] id_s2;
	logic        ext_s2;
	logic [63:0] data_s2;
	logic [3:0]  len_s2;
	logic        rev_s2;
	logic        rwin_s2;
	logic        pop_s2;

	logic s2_free;
	logic fire;

	assign s2_free    = ~valid_s2 | result.ready;
	assign fire       = valid_s1 & s2_free;
	assign item.ready = ~valid_s1 | s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1   <= cmd_t'(item.cmd);
			cnt_s1   <= item.sync_count;
			now_s1   <= item.now_time;
			data_s1  <= item.frame_data;
			len_s1   <= item.frame_len;
			fault_s1 <= item.map_fault;
		end
	end

	// length clamp and byte masking
	logic [3:0]  len_c;
	logic [63:0] data_c;

	always_comb begin
		len_c = (len_s1 > 4'd8) ? 4'd8 : len_s1;
		for (int b = 0; b < 8; b++) begin
			data_c[8*b +: 8] = (4'(b) < len_c) ? data_s1[8*b +: 8] : 8'd0;
		end
	end

	// decision
	logic              pvalid;
	logic [7:0]        tt;
	act_t              act_n;
	logic              send_n;
	logic              push_n;
	logic              pop_n;
	logic              rev_n;
	logic              rwin_n;
	logic              ep_n;
	logic              we_n;
	logic [7:0]        sw_n;
	logic [7:0]        sc_n;
	logic [TIME_W-1:0] na_n;
	logic [7:0]        sc_base;
	logic [7:0]        sc_inc;
	logic              go;
	logic [TIME_W:0]   inh_sum;
	logic [TIME_W-1:0] inh_end;

	assign pvalid  = ~cfg.cob_id[31];
	assign tt      = cfg.trans_type;
	assign inh_sum = {1'b0, now_s1} + {{(TIME_W+1-16){1'b0}}, cfg.inhibit_time};
	assign inh_end = inh_sum[TIME_W] ? {TIME_W{1'b1}} : inh_sum[TIME_W-1:0];

	always_comb begin
		act_n   = ACT_NONE;
		send_n  = 1'b0;
		push_n  = 1'b0;
		pop_n   = 1'b0;
		rev_n   = 1'b0;
		rwin_n  = 1'b0;
		ep_n    = ep_q;
		we_n    = we_q;
		sw_n    = sw_q;
		sc_n    = sc_q;
		na_n    = na_q;
		sc_base = sc_q;
		sc_inc  = 8'd0;
		go      = 1'b0;
		case (cmd_s1)
			CMD_EVENT: begin
				if (pvalid && tt == TT_ACYCLIC) begin
					if (!ep_q) ep_n = ~we_q;
					rev_n = (cfg.event_period != 16'd0);
				end else if (pvalid && tt >= TT_EVT_MIN) begin
					if (cfg.inhibit_time != 16'd0 && now_s1 < na_q) begin
						act_n = ACT_INHIBIT;
					end else if (fault_s1) begin
						act_n = ACT_FAULT;
						if (cfg.inhibit_time != 16'd0) na_n = now_s1;
					end else begin
						act_n  = ACT_SEND;
						send_n = 1'b1;
						rev_n  = (cfg.event_period != 16'd0);
						if (cfg.inhibit_time != 16'd0) na_n = inh_end;
					end
				end
			end
			CMD_SYNC: begin
				if (cnt_s1 > SYNC_CNT_MAX) begin
					act_n = ACT_BAD_CNT;
				end else if (pvalid && (tt <= TT_CYC_MAX || tt == TT_RTR_SYNC)) begin
					we_n   = 1'b0;
					rwin_n = (cfg.window_length != 32'd0);
					go     = 1'b1;
					if (sw_q != 8'd0 && cnt_s1 != 8'd0) begin
						if (sw_q != cnt_s1) begin
							go = 1'b0;
						end else begin
							sw_n    = 8'd0;
							sc_n    = 8'd0;
							sc_base = 8'd0;
						end
					end
					if (go) begin
						if (tt == TT_ACYCLIC) begin
							if (!ep_q) go = 1'b0;
							else ep_n = 1'b0;
						end else if (tt <= TT_CYC_MAX) begin
							sc_inc = sc_base + 8'd1;
							if (sc_inc < tt) begin
								sc_n = sc_inc;
								go   = 1'b0;
							end else begin
								sc_n = 8'd0;
							end
						end
					end
					if (go) begin
						if (fault_s1) begin
							act_n = ACT_FAULT;
						end else if (tt <= TT_CYC_MAX) begin
							act_n  = ACT_SEND;
							send_n = 1'b1;
						end else if (fill_q < QF_W'(Q_DEPTH)) begin
							act_n  = ACT_BUFFER;
							push_n = 1'b1;
						end else begin
							act_n = ACT_FULL;
						end
					end
				end
			end
			CMD_RTR: begin
				if (pvalid && (tt == TT_RTR_SYNC || tt == TT_RTR_ONLY)) begin
					if (tt == TT_RTR_SYNC && fill_q != '0) begin
						act_n = ACT_SEND;
						pop_n = 1'b1;
					end else if (fault_s1) begin
						act_n = ACT_FAULT;
					end else begin
						act_n  = ACT_SEND;
						send_n = 1'b1;
					end
				end
			end
			default: begin
				if (pvalid && (tt <= TT_CYC_MAX || tt == TT_RTR_SYNC)) begin
					we_n  = 1'b1;
					act_n = ACT_WIN_TO;
				end
			end
		endcase
	end

	// FIFO pointers
	logic [QS_W-1:0] tail_sum;
	logic [QA_W-1:0] tail;
	logic [QA_W-1:0] head_inc;

	assign tail_sum = {1'b0, head_q} + QS_W'(fill_q);
	assign tail     = (tail_sum >= QS_W'(Q_DEPTH)) ?
	                  QA_W'(tail_sum - QS_W'(Q_DEPTH)) : tail_sum[QA_W-1:0];
	assign head_inc = (QS_W'(head_q) + QS_W'(1) == QS_W'(Q_DEPTH)) ?
	                  '0 : QA_W'(QS_W'(head_q) + QS_W'(1));

	// state update; the user must keep config writes to times when no item is in flight; the block does no check of this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ep_q   <= 1'b0;
			we_q   <= 1'b0;
			sw_q   <= 8'd0;
			sc_q   <= 8'd0;
			na_q   <= '0;
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_evt.clr_pending) ep_q <= 1'b0;
			else if (fire) ep_q <= ep_n;

			if (fire) we_q <= we_n;

			if (cfg_evt.revalidate) begin
				sw_q <= cfg.sync_start;
				sc_q <= 8'd0;
				na_q <= '0;
			end else if (fire) begin
				sw_q <= sw_n;
				sc_q <= sc_n;
				na_q <= na_n;
			end

			if (cfg_evt.clr_queue) begin
				head_q <= '0;
				fill_q <= '0;
			end else if (fire && push_n) begin
				fill_q <= fill_q + QF_W'(1);
			end else if (fire && pop_n) begin
				head_q <= head_inc;
				fill_q <= fill_q - QF_W'(1);
			end
		end
	end

	// frame FIFO memory: {len, data}
	always_ff @(posedge clk) begin
		if (fire && push_n) mem[tail] <= {len_c, data_c};
		if (fire && pop_n)  rd_q <= mem[head_q];
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			act_s2  <= act_n;
			ext_s2  <= (send_n | pop_n) & cfg.cob_id[29];
			if (send_n || pop_n) begin
				id_s2 <= cfg.cob_id[29] ? cfg.cob_id[28:0] : {18'd0, cfg.cob_id[10:0]};
			end else begin
				id_s2 <= '0;
			end
			data_s2 <= send_n ? data_c : 64'd0;
			len_s2  <= send_n ? len_c : 4'd0;
			rev_s2  <= rev_n;
			rwin_s2 <= rwin_n;
			pop_s2  <= pop_n;
		end
	end

	assign result.valid              = valid_s2;
	assign result.action             = act_s2;
	assign result.can_id             = id_s2;
	assign result.extended_id        = ext_s2;
	assign result.payload            = pop_s2 ? rd_q[63:0] : data_s2;
	assign result.payload_len        = pop_s2 ? rd_q[67:64] : len_s2;
	assign result.rearm_event_timer  = rev_s2;
	assign result.rearm_window_timer = rwin_s2;

endmodule
